// ===== hdl/srq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the sorted table range query block.
// Depends on nothing; used by every other file of the block except srq_ram.
package srq_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int INDEX_W = 10;
   localparam int POS_W   = 31;
   localparam int OFS_W   = 63;
   localparam int COUNT_W = 11;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic STATUS_FOUND = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic             command;
      logic [IDX_W-1:0] slot;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] range_end;
      logic [OFS_W-1:0] offset;
   } item_type;

endpackage

// ===== hdl/srq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module srq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/srq_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request items, drops loads aimed past the table and
// queues the rest in a short in-order queue. Depends on srq_pkg.
module srq_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_command,
   input  logic [srq_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [srq_pkg::POS_W-1:0] req_position,
   input  logic [srq_pkg::POS_W-1:0] req_range_end,
   input  logic [srq_pkg::OFS_W-1:0] req_entry_offset,
   output logic                      item_valid,
   output srq_pkg::item_type         item,
   input  logic                      item_take
);
   import srq_pkg::*;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                accept;
   logic                in_range;
   logic                enqueue;
   logic                dequeue;
   item_type            new_item;

   assign req_full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept     = req_push && !req_full;
   assign in_range   = (32'(req_entry_index) < 32'(TABLE_DEPTH));
   // A load to a slot beyond the table has no effect, so it never enters the queue.
   assign enqueue    = accept && ((req_command == CMD_QUERY) || in_range);
   assign item_valid = (count_ff != '0);
   assign dequeue    = item_valid && item_take;
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.command   = req_command;
      new_item.slot      = IDX_W'(req_entry_index);
      new_item.position  = req_position;
      new_item.range_end = req_range_end;
      new_item.offset    = req_entry_offset;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enqueue) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (dequeue) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enqueue && !dequeue) begin
         count_in = count_ff + 1'b1;
      end else if (dequeue && !enqueue) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enqueue) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== hdl/srq_back.sv =====
`timescale 1ns / 1ps
// Back end: executes queued items in order. Loads write the tables; queries
// run the lower and upper bound searches and fill the result register.
// Depends on srq_pkg and srq_ram.
module srq_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [srq_pkg::COUNT_W-1:0] entry_count,
   input  logic                        item_valid,
   input  srq_pkg::item_type           item,
   output logic                        item_take,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic                        rsp_status,
   output logic [srq_pkg::COUNT_W-1:0] rsp_match_count,
   output logic [srq_pkg::OFS_W-1:0]   rsp_first_offset
);
   import srq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOWER  = 4'b0010,
      ST_UPPER  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   first_ff, first_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   probe_ff, probe_in;
   logic [CNT_W-1:0]   half_ff, half_in;
   logic               pend_ff, pend_in;
   logic [CNT_W-1:0]   lb_ff, lb_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   begin_ff, begin_in;
   logic [POS_W-1:0]   end_ff, end_in;
   logic               out_valid_ff, out_valid_in;
   logic               status_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [OFS_W-1:0]   offset_ff;

   logic [CNT_W-1:0]   limit;
   logic [CNT_W-1:0]   first_n, len_n, half_n, probe_n;
   logic [POS_W-1:0]   pos_rd_data, key;
   logic [OFS_W-1:0]   ofs_rd_data;
   logic               advance;
   logic               searching;
   logic               table_we;
   logic               pos_rd_en;
   logic               ofs_rd_en;
   logic               out_load;

   assign limit = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(entry_count);

   assign searching = (state_ff == ST_LOWER) || (state_ff == ST_UPPER);
   assign key       = (state_ff == ST_UPPER) ? end_ff : begin_ff;
   // Lower bound stops at the first position >= begin, upper at the first > end.
   assign advance   = (state_ff == ST_UPPER) ? (pos_rd_data <= key) : (pos_rd_data < key);

   // Resolve the probe that was read last cycle, then pick the next probe.
   always_comb begin
      if (pend_ff && advance) begin
         first_n = probe_ff + 1'b1;
         len_n   = len_ff - half_ff - 1'b1;
      end else if (pend_ff) begin
         first_n = first_ff;
         len_n   = half_ff;
      end else begin
         first_n = first_ff;
         len_n   = len_ff;
      end
      half_n  = len_n >> 1;
      probe_n = first_n + half_n;
   end

   assign item_take = (state_ff == ST_IDLE) && item_valid;
   assign table_we  = item_take && (item.command == CMD_LOAD);
   assign pos_rd_en = searching && (len_n != '0);
   assign ofs_rd_en = (state_ff == ST_UPPER) && (len_n == '0) && (first_n != lb_ff);
   assign out_load  = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_pop);

   srq_ram #(.WIDTH(POS_W), .DEPTH(TABLE_DEPTH)) u_pos_ram (
      .clock   (clock),
      .wr_en   (table_we),
      .wr_addr (item.slot),
      .wr_data (item.position),
      .rd_en   (pos_rd_en),
      .rd_addr (IDX_W'(probe_n)),
      .rd_data (pos_rd_data)
   );

   srq_ram #(.WIDTH(OFS_W), .DEPTH(TABLE_DEPTH)) u_ofs_ram (
      .clock   (clock),
      .wr_en   (table_we),
      .wr_addr (item.slot),
      .wr_data (item.offset),
      .rd_en   (ofs_rd_en),
      .rd_addr (IDX_W'(lb_ff)),
      .rd_data (ofs_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      len_in       = len_ff;
      probe_in     = probe_ff;
      half_in      = half_ff;
      pend_in      = pend_ff;
      lb_in        = lb_ff;
      cnt_in       = cnt_ff;
      begin_in     = begin_ff;
      end_in       = end_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_take && (item.command == CMD_QUERY)) begin
               begin_in = item.position;
               end_in   = item.range_end;
               first_in = '0;
               len_in   = limit;
               pend_in  = 1'b0;
               state_in = ST_LOWER;
            end
         end
         ST_LOWER: begin
            first_in = first_n;
            len_in   = len_n;
            probe_in = probe_n;
            half_in  = half_n;
            pend_in  = (len_n != '0);
            if (len_n == '0) begin
               lb_in    = first_n;
               len_in   = limit - first_n;
               state_in = ST_UPPER;
            end
         end
         ST_UPPER: begin
            first_in = first_n;
            len_in   = len_n;
            probe_in = probe_n;
            half_in  = half_n;
            pend_in  = (len_n != '0);
            if (len_n == '0) begin
               cnt_in   = first_n - lb_ff;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      len_ff   <= len_in;
      probe_ff <= probe_in;
      half_ff  <= half_in;
      lb_ff    <= lb_in;
      cnt_ff   <= cnt_in;
      begin_ff <= begin_in;
      end_ff   <= end_in;
      if (out_load) begin
         if (cnt_ff == '0) begin
            status_ff <= STATUS_EMPTY;
            count_ff  <= '0;
            offset_ff <= '0;
         end else begin
            status_ff <= STATUS_FOUND;
            count_ff  <= COUNT_W'(cnt_ff);
            offset_ff <= ofs_rd_data;
         end
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_match_count  = count_ff;
   assign rsp_first_offset = offset_ff;

endmodule

// ===== hdl/sorted_table_range_query_top.sv =====
`timescale 1ns / 1ps
// Sorted table range query, top level. An accepted load is queued and written to the tables once
// the idle back end takes it, and loads stream at one item per cycle while the back end is idle.
// A query runs a lower bound and then an upper bound search over the searched entry count, and
// the back end takes its next item only after the query's result is loaded into the result
// register; the position memory's single read port serves one probe per cycle.
// Reset clears the control state and entry_count; the tables are not cleared.
module sorted_table_range_query_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic                        req_command,
   input  logic [srq_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [srq_pkg::POS_W-1:0]   req_position,
   input  logic [srq_pkg::POS_W-1:0]   req_range_end,
   input  logic [srq_pkg::OFS_W-1:0]   req_entry_offset,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic                        rsp_status,
   output logic [srq_pkg::COUNT_W-1:0] rsp_match_count,
   output logic [srq_pkg::OFS_W-1:0]   rsp_first_offset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [srq_pkg::COUNT_W-1:0] csr_entry_count
);
   import srq_pkg::*;

   logic [COUNT_W-1:0] entry_count_ff;
   logic               item_valid;
   logic               item_take;
   item_type           item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         entry_count_ff <= csr_entry_count;
      end
   end

   srq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_entry_index  (req_entry_index),
      .req_position     (req_position),
      .req_range_end    (req_range_end),
      .req_entry_offset (req_entry_offset),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   srq_back u_back (
      .clock            (clock),
      .reset            (reset),
      .entry_count      (entry_count_ff),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_status       (rsp_status),
      .rsp_match_count  (rsp_match_count),
      .rsp_first_offset (rsp_first_offset)
   );

endmodule

// ===== hdl/srq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the sorted table range query top level, and the bind
// that attaches them. Depends on srq_pkg.
module srq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic                        rsp_status,
   input logic [srq_pkg::COUNT_W-1:0] rsp_match_count,
   input logic [srq_pkg::OFS_W-1:0]   rsp_first_offset
);
   import srq_pkg::*;

   // Reset leaves both queues empty.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_status) &&
         $stable(rsp_match_count) && $stable(rsp_first_offset)))
      else $error("waiting result item changed");

   // An empty range reports zero count and zero offset.
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_EMPTY) |->
         (rsp_match_count == '0 && rsp_first_offset == '0))
      else $error("empty range with nonzero fields");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_FOUND) |->
         (rsp_match_count != '0 && 32'(rsp_match_count) <= 32'(TABLE_DEPTH)))
      else $error("found result with bad count");

endmodule

bind sorted_table_range_query_top srq_checker u_srq_checker (.*);
